// ----- src/swfe_pkg.sv -----
// Package for the stopwatch serial frame encoder.
// Holds the item kinds, frame characters, digit and snapshot types, and the
// status mapping. No dependencies.
`timescale 1ns / 1ps

package swfe_pkg;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PAD_NONE  = 2'd0,
    PAD_BOTH  = 2'd1,
    PAD_RIGHT = 2'd2,
    PAD_LEFT  = 2'd3
  } pad_t;

  localparam logic [7:0] CHAR_IDLE  = 8'h49;  // 'I'
  localparam logic [7:0] CHAR_RIGHT = 8'h52;  // 'R'
  localparam logic [7:0] CHAR_LEFT  = 8'h4C;  // 'L'
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;  // '0'..'9' are 0x30..0x39
  localparam logic [1:0] CHECKSUM_HI    = 2'b01; // 64 plus a sum below 64

  typedef logic [3:0] digit_t;

  localparam digit_t DIGIT_MAX    = 4'd9;
  localparam digit_t SEC_TENS_MAX = 4'd5;
  localparam digit_t MIN_TENS_TOP = 4'd10;  // minutes = 100, count stopped

  localparam int NUM_DIGITS = 6;
  localparam int SUM_W      = 6;  // six digits of at most 9 sum to 54

  // Digits in frame order: minute ones, second tens and ones,
  // millisecond hundreds, tens and ones.
  typedef struct packed {
    digit_t min1;
    digit_t sec10;
    digit_t sec1;
    digit_t ms100;
    digit_t ms10;
    digit_t ms1;
  } time_digits_t;

  typedef struct packed {
    logic [7:0]   status;
    time_digits_t digits;
  } frame_snap_t;

  localparam int FRAME_LEN = 10;
  localparam int IDX_W     = $clog2(FRAME_LEN);
  typedef logic [IDX_W-1:0] frame_idx_t;

  localparam frame_idx_t IDX_STATUS = IDX_W'(0);
  localparam frame_idx_t IDX_MIN1   = IDX_W'(1);
  localparam frame_idx_t IDX_SEC10  = IDX_W'(2);
  localparam frame_idx_t IDX_SEC1   = IDX_W'(3);
  localparam frame_idx_t IDX_MS100  = IDX_W'(4);
  localparam frame_idx_t IDX_MS10   = IDX_W'(5);
  localparam frame_idx_t IDX_MS1    = IDX_W'(6);
  localparam frame_idx_t IDX_SUM    = IDX_W'(7);
  localparam frame_idx_t IDX_CR     = IDX_W'(8);
  localparam frame_idx_t IDX_LF     = IDX_W'(FRAME_LEN - 1);

  // The idle status shows which single pad is touched.
  function automatic logic [7:0] map_status(input logic [7:0] status,
                                            input logic [1:0] pad);
    logic [7:0] st;
    st = status;
    if (status == CHAR_IDLE) begin
      if (pad == PAD_RIGHT) st = CHAR_RIGHT;
      else if (pad == PAD_LEFT) st = CHAR_LEFT;
    end
    return st;
  endfunction

  function automatic logic [7:0] digit_char(input digit_t d);
    return {ASCII_DIGIT_HI, d};
  endfunction

endpackage

// ----- src/swfe_if.sv -----
// Valid/ready channel interfaces for the stopwatch serial frame encoder.
// Depends on nothing; payload widths follow the item fields.
`timescale 1ns / 1ps

interface swfe_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] status_char;
  logic [1:0] pad_state;

  modport source (output valid, output kind, output status_char,
                  output pad_state, input ready);
  modport sink   (input valid, input kind, input status_char,
                  input pad_state, output ready);
endinterface

interface swfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// ----- src/swfe_time_counter.sv -----
// BCD minutes/seconds/milliseconds counter with stop mark at 100 minutes.
// Depends on swfe_pkg.
`timescale 1ns / 1ps

module swfe_time_counter (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   tick,
  input  logic                   clear,
  output swfe_pkg::time_digits_t digits
);

  swfe_pkg::digit_t min10_r, min10_nxt;
  swfe_pkg::digit_t min1_r, min1_nxt;
  swfe_pkg::digit_t sec10_r, sec10_nxt;
  swfe_pkg::digit_t sec1_r, sec1_nxt;
  swfe_pkg::digit_t ms100_r, ms100_nxt;
  swfe_pkg::digit_t ms10_r, ms10_nxt;
  swfe_pkg::digit_t ms1_r, ms1_nxt;
  logic             stopped_r, stopped_nxt;

  // Each digit rolls over only when all lower digits roll over.
  always_comb begin
    min10_nxt   = min10_r;
    min1_nxt    = min1_r;
    sec10_nxt   = sec10_r;
    sec1_nxt    = sec1_r;
    ms100_nxt   = ms100_r;
    ms10_nxt    = ms10_r;
    ms1_nxt     = ms1_r;
    stopped_nxt = stopped_r;
    if (clear) begin
      min10_nxt   = '0;
      min1_nxt    = '0;
      sec10_nxt   = '0;
      sec1_nxt    = '0;
      ms100_nxt   = '0;
      ms10_nxt    = '0;
      ms1_nxt     = '0;
      stopped_nxt = 1'b0;
    end else if (tick && !stopped_r) begin
      if (ms1_r != swfe_pkg::DIGIT_MAX) begin
        ms1_nxt = ms1_r + 4'd1;
      end else begin
        ms1_nxt = '0;
        if (ms10_r != swfe_pkg::DIGIT_MAX) begin
          ms10_nxt = ms10_r + 4'd1;
        end else begin
          ms10_nxt = '0;
          if (ms100_r != swfe_pkg::DIGIT_MAX) begin
            ms100_nxt = ms100_r + 4'd1;
          end else begin
            ms100_nxt = '0;
            if (sec1_r != swfe_pkg::DIGIT_MAX) begin
              sec1_nxt = sec1_r + 4'd1;
            end else begin
              sec1_nxt = '0;
              if (sec10_r != swfe_pkg::SEC_TENS_MAX) begin
                sec10_nxt = sec10_r + 4'd1;
              end else begin
                sec10_nxt = '0;
                if (min1_r != swfe_pkg::DIGIT_MAX) begin
                  min1_nxt = min1_r + 4'd1;
                end else begin
                  min1_nxt = '0;
                  if (min10_r != swfe_pkg::DIGIT_MAX) begin
                    min10_nxt = min10_r + 4'd1;
                  end else begin
                    min10_nxt   = swfe_pkg::MIN_TENS_TOP;
                    stopped_nxt = 1'b1;
                  end
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min10_r   <= '0;
      min1_r    <= '0;
      sec10_r   <= '0;
      sec1_r    <= '0;
      ms100_r   <= '0;
      ms10_r    <= '0;
      ms1_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      min10_r   <= min10_nxt;
      min1_r    <= min1_nxt;
      sec10_r   <= sec10_nxt;
      sec1_r    <= sec1_nxt;
      ms100_r   <= ms100_nxt;
      ms10_r    <= ms10_nxt;
      ms1_r     <= ms1_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  assign digits = '{min1: min1_r, sec10: sec10_r, sec1: sec1_r,
                    ms100: ms100_r, ms10: ms10_r, ms1: ms1_r};

  // A stopped count sits at exactly 100:00.000.
  a_stopped_at_top: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |-> (min10_r == swfe_pkg::MIN_TENS_TOP) && (min1_r == '0) &&
                  (sec10_r == '0) && (sec1_r == '0) && (ms100_r == '0) &&
                  (ms10_r == '0) && (ms1_r == '0))
    else $error("stopped count is not at 100 minutes");

  a_tick_steps_ms: assert property (@(posedge clk) disable iff (!rst_n)
    tick && !clear && !stopped_r && (ms1_r != swfe_pkg::DIGIT_MAX)
      |=> (ms1_r == $past(ms1_r) + 4'd1) && $stable(ms10_r) && $stable(sec1_r))
    else $error("tick did not add one millisecond");

  a_digits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ms1_r <= swfe_pkg::DIGIT_MAX) && (ms10_r <= swfe_pkg::DIGIT_MAX) &&
    (ms100_r <= swfe_pkg::DIGIT_MAX) && (sec1_r <= swfe_pkg::DIGIT_MAX) &&
    (sec10_r <= swfe_pkg::SEC_TENS_MAX) && (min1_r <= swfe_pkg::DIGIT_MAX))
    else $error("BCD digit out of range");

endmodule

// ----- src/swfe_frame_ser.sv -----
// Frame serializer: holds one time snapshot, sends its ten bytes through an
// output register one per cycle unless stalled. Depends on swfe_pkg, swfe_if.
`timescale 1ns / 1ps

module swfe_frame_ser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  swfe_pkg::frame_snap_t snap,
  output logic                  busy,
  swfe_out_if.source            out_rsp
);

  swfe_pkg::frame_snap_t       snap_r;
  logic [swfe_pkg::SUM_W-1:0]  sum_r;
  swfe_pkg::frame_idx_t        idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;
  logic [7:0]                  byte_sel;
  logic                        out_take;
  logic                        advance;
  logic [swfe_pkg::SUM_W-1:0]  snap_sum;

  assign snap_sum = swfe_pkg::SUM_W'(snap.digits.min1) +
                    swfe_pkg::SUM_W'(snap.digits.sec10) +
                    swfe_pkg::SUM_W'(snap.digits.sec1) +
                    swfe_pkg::SUM_W'(snap.digits.ms100) +
                    swfe_pkg::SUM_W'(snap.digits.ms10) +
                    swfe_pkg::SUM_W'(snap.digits.ms1);

  assign out_take = out_valid_r && out_rsp.ready;
  // The next byte moves up whenever the output register is empty or emptying.
  assign advance  = pend_r && (!out_valid_r || out_take);

  always_comb begin
    case (idx_r)
      swfe_pkg::IDX_STATUS: byte_sel = snap_r.status;
      swfe_pkg::IDX_MIN1:   byte_sel = swfe_pkg::digit_char(snap_r.digits.min1);
      swfe_pkg::IDX_SEC10:  byte_sel = swfe_pkg::digit_char(snap_r.digits.sec10);
      swfe_pkg::IDX_SEC1:   byte_sel = swfe_pkg::digit_char(snap_r.digits.sec1);
      swfe_pkg::IDX_MS100:  byte_sel = swfe_pkg::digit_char(snap_r.digits.ms100);
      swfe_pkg::IDX_MS10:   byte_sel = swfe_pkg::digit_char(snap_r.digits.ms10);
      swfe_pkg::IDX_MS1:    byte_sel = swfe_pkg::digit_char(snap_r.digits.ms1);
      swfe_pkg::IDX_SUM:    byte_sel = {swfe_pkg::CHECKSUM_HI, sum_r};
      swfe_pkg::IDX_CR:     byte_sel = swfe_pkg::CHAR_CR;
      swfe_pkg::IDX_LF:     byte_sel = swfe_pkg::CHAR_LF;
      default:              byte_sel = swfe_pkg::CHAR_LF;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt  = swfe_pkg::IDX_STATUS;
      pend_nxt = 1'b1;
    end else if (advance) begin
      idx_nxt = idx_r + 1'b1;
      if (idx_r == swfe_pkg::IDX_LF) pend_nxt = 1'b0;
    end
    if (advance) out_valid_nxt = 1'b1;
    else if (out_take) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= swfe_pkg::IDX_STATUS;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r <= snap;
      sum_r  <= snap_sum;
    end
    if (advance) begin
      out_byte_r <= byte_sel;
      out_last_r <= (idx_r == swfe_pkg::IDX_LF);
    end
  end

  // A new frame may be taken at the edge where the current LF moves up.
  assign busy              = pend_r && !(advance && (idx_r == swfe_pkg::IDX_LF));
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.frame_byte = out_byte_r;
  assign out_rsp.last_byte = out_last_r;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !pend_r || (advance && (idx_r == swfe_pkg::IDX_LF)))
    else $error("frame loaded over a frame still being sent");

  a_idx_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (idx_r <= swfe_pkg::IDX_LF))
    else $error("byte index beyond the frame");

  a_lf_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (idx_r == swfe_pkg::IDX_LF) && !load
      |=> !pend_r && out_valid_r && out_last_r &&
          (out_byte_r == swfe_pkg::CHAR_LF))
    else $error("frame did not end with a flagged LF");

endmodule

// ----- src/stopwatch_serial_frame_encoder.sv -----
// Top level of the stopwatch serial frame encoder.
// Depends on swfe_pkg, swfe_if, swfe_time_counter and swfe_frame_ser.
//
// Usage:
//   in_req (sink) takes requests: kind 0 adds one millisecond, kind 2 clears
//   the time and the stop mark, kind 1 asks for a frame, kind 3 is ignored.
//   Each frame request yields ten bytes on out_rsp (source): status, six
//   ASCII digits (minute ones, seconds, milliseconds), checksum, CR and LF,
//   with last_byte set on the LF.
//   Tick and clear requests are taken every cycle and act at the accepting
//   edge; a frame shows every request accepted before it.
//   A frame request snapshots the time when accepted; its bytes then pass one
//   at a time through the output register, one per cycle while out_rsp is
//   ready. The next frame request is taken at the edge where the LF of the
//   current one moves into the output register, so frames run back to back,
//   one byte per cycle on out_rsp when it does not stall.
//   While a frame is still being sent, in_req.ready is low only for another
//   frame request; ticks and clears keep flowing.
//   A stall on out_rsp holds the current byte and the rest of the frame.
//   Reset (rst_n low, synchronous) zeroes the time and the stop mark and
//   drops any frame in progress.
`timescale 1ns / 1ps

module stopwatch_serial_frame_encoder (
  input  logic     clk,
  input  logic     rst_n,
  swfe_in_if.sink  in_req,
  swfe_out_if.source out_rsp
);

  logic                   in_fire;
  logic                   ser_busy;
  logic                   tick;
  logic                   clear;
  logic                   load;
  swfe_pkg::time_digits_t digits;
  swfe_pkg::frame_snap_t  snap;

  assign in_req.ready = (in_req.kind != swfe_pkg::KIND_FRAME) || !ser_busy;
  assign in_fire      = in_req.valid && in_req.ready;
  assign tick         = in_fire && (in_req.kind == swfe_pkg::KIND_TICK);
  assign clear        = in_fire && (in_req.kind == swfe_pkg::KIND_CLEAR);
  assign load         = in_fire && (in_req.kind == swfe_pkg::KIND_FRAME);

  assign snap = '{status: swfe_pkg::map_status(in_req.status_char, in_req.pad_state),
                  digits: digits};

  swfe_time_counter u_counter (
    .clk    (clk),
    .rst_n  (rst_n),
    .tick   (tick),
    .clear  (clear),
    .digits (digits)
  );

  swfe_frame_ser u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .snap    (snap),
    .busy    (ser_busy),
    .out_rsp (out_rsp)
  );

endmodule

// ----- tb/swfe_frame_checker.sv -----
`timescale 1ns / 1ps
// Checker for the stopwatch serial frame encoder: keeps its own stopwatch,
// predicts each frame and compares every byte. Depends on swfe_pkg and swfe_if.

module swfe_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  swfe_in_if         in_ch,
  swfe_out_if        out_ch,
  output int         fail_count,
  output int         bytes_due
);

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam int         CHECKSUM_BASE = 64;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } frame_char_t;

  frame_char_t pending_bytes[$];

  logic [9:0] millis;
  logic [5:0] seconds;
  logic [6:0] minutes;
  logic       stopped;

  function automatic void expect_byte(input logic [7:0] value, input logic is_last);
    frame_char_t fc;
    fc.value   = value;
    fc.is_last = is_last;
    pending_bytes.push_back(fc);
  endfunction

  task automatic clear_time();
    millis  = '0;
    seconds = '0;
    minutes = '0;
    stopped = 1'b0;
  endtask

  task automatic advance_millisecond();
    if (!stopped) begin
      if (millis == 10'd999) begin
        millis = '0;
        if (seconds == 6'd59) begin
          seconds = '0;
          // The count freezes at one hundred minutes.
          if (minutes == 7'd99) begin
            minutes = 7'd100;
            stopped = 1'b1;
          end else begin
            minutes = minutes + 7'd1;
          end
        end else begin
          seconds = seconds + 6'd1;
        end
      end else begin
        millis = millis + 10'd1;
      end
    end
  endtask

  task automatic queue_frame(input logic [7:0] status, input logic [1:0] pad);
    int         digit [6];
    int         sum;
    int         i;
    logic [7:0] shown;
    digit[0] = minutes % 10;
    digit[1] = seconds / 10;
    digit[2] = seconds % 10;
    digit[3] = millis / 100;
    digit[4] = (millis / 10) % 10;
    digit[5] = millis % 10;
    shown = status;
    if (status == swfe_pkg::CHAR_IDLE && pad == swfe_pkg::PAD_RIGHT)
      shown = swfe_pkg::CHAR_RIGHT;
    else if (status == swfe_pkg::CHAR_IDLE && pad == swfe_pkg::PAD_LEFT)
      shown = swfe_pkg::CHAR_LEFT;
    expect_byte(shown, 1'b0);
    sum = 0;
    for (i = 0; i < 6; i++) begin
      expect_byte(ASCII_ZERO + 8'(digit[i]), 1'b0);
      sum += digit[i];
    end
    expect_byte(8'(CHECKSUM_BASE + sum), 1'b0);
    expect_byte(swfe_pkg::CHAR_CR, 1'b0);
    expect_byte(swfe_pkg::CHAR_LF, 1'b1);
  endtask

  always @(posedge clk) begin
    frame_char_t want;
    if (!rst_n) begin
      clear_time();
      pending_bytes.delete();
      bytes_due <= 0;
    end else begin
      // Bytes leaving at this edge belong to frames requested earlier.
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected frame byte %02h (last %0b)", out_ch.frame_byte,
                 out_ch.last_byte);
          fail_count++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_ch.frame_byte !== want.value) begin
            $error("frame_byte: expected %02h, got %02h", want.value,
                   out_ch.frame_byte);
            fail_count++;
          end
          if (out_ch.last_byte !== want.is_last) begin
            $error("last_byte: expected %0b, got %0b", want.is_last,
                   out_ch.last_byte);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.kind)
          swfe_pkg::KIND_TICK:  advance_millisecond();
          swfe_pkg::KIND_CLEAR: clear_time();
          swfe_pkg::KIND_FRAME: queue_frame(in_ch.status_char, in_ch.pad_state);
          default: ;
        endcase
      end
      bytes_due <= pending_bytes.size();
    end
  end

endmodule

// ----- tb/tb_stopwatch_serial_frame_encoder.sv -----
`timescale 1ns / 1ps
// Testbench top for the stopwatch serial frame encoder: drives requests,
// stalls the byte stream and gives the verdict. Depends on swfe_pkg, swfe_if
// and swfe_frame_checker.

module tb_stopwatch_serial_frame_encoder;

  localparam int RANDOM_ITEMS    = 460;
  localparam int HOLD_LEN        = 400;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam int RX_FULL   = 0;
  localparam int RX_BUSY   = 1;
  localparam int RX_SLOW   = 2;
  localparam int RX_TOGGLE = 3;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   bytes_due;
  int   hold_asks;
  int   holds_done;
  int   hold_left;
  int   rx_mode;
  int   rx_left;
  int   quiet_cycles;

  always #1 clk = ~clk;

  swfe_in_if  in_ch ();
  swfe_out_if out_ch ();

  stopwatch_serial_frame_encoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_rsp (out_ch)
  );

  swfe_frame_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .bytes_due  (bytes_due)
  );

  // Byte receiver: stretches of differing stall patterns, plus long holds on demand.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      holds_done   <= 0;
      hold_left    <= 0;
      rx_mode      <= RX_FULL;
      rx_left      <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_asks != holds_done) begin
      out_ch.ready <= 1'b0;
      hold_left    <= HOLD_LEN - 1;
      holds_done   <= holds_done + 1;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(RX_FULL, RX_TOGGLE);
        rx_left <= $urandom_range(20, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        RX_FULL:   out_ch.ready <= 1'b1;
        RX_BUSY:   out_ch.ready <= ($urandom_range(0, 3) != 0);
        RX_SLOW:   out_ch.ready <= ($urandom_range(0, 3) == 0);
        default:   out_ch.ready <= ~out_ch.ready;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_stopwatch_serial_frame_encoder NOT OK");
        $finish;
      end
    end
  end

  // Holds valid high until the request is taken; returns at the accepting edge.
  task automatic offer_request(input swfe_pkg::kind_t kind, input logic [7:0] status,
                               input logic [1:0] pad);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.status_char <= status;
    in_ch.pad_state   <= pad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_ch.valid <= 1'b0;
    in_ch.kind  <= 2'($urandom_range(0, 3));
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_for_frames_out();
    pause_sender(1);
    while (bytes_due != 0) @(posedge clk);
  endtask

  initial begin
    int         items;
    int         burst_left;
    int         roll;
    int         n;
    logic [7:0] status;
    logic [1:0] pad;
    bit         held;
    bit         drained;

    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= swfe_pkg::KIND_TICK;
    in_ch.status_char <= 8'h00;
    in_ch.pad_state   <= swfe_pkg::PAD_NONE;
    hold_asks         <= 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: idle status mapping for every pad, status extremes, the
    // ignored kind, ticks and clears.
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_RIGHT);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_BOTH);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_RIGHT, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_FRAME, 8'h00, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_FRAME, 8'hFF, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_TICK, 8'hFF, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_TICK, 8'h00, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_FRAME, 8'hA5, swfe_pkg::PAD_RIGHT);
    offer_request(swfe_pkg::KIND_UNUSED, 8'hFF, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_FRAME, 8'h5A, swfe_pkg::PAD_BOTH);
    offer_request(swfe_pkg::KIND_CLEAR, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_RIGHT);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_RIGHT);
    offer_request(swfe_pkg::KIND_TICK, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_CLEAR, 8'hFF, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_LEFT, swfe_pkg::PAD_RIGHT);

    items      = 0;
    burst_left = 0;
    held       = 1'b0;
    drained    = 1'b0;
    while (items < RANDOM_ITEMS) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
        burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      status = ($urandom_range(0, 1) == 0) ? swfe_pkg::CHAR_IDLE
                                           : 8'($urandom_range(0, 255));
      pad    = 2'($urandom_range(0, 3));

      if (!held && items >= 150) begin
        // Stall the byte stream for a long while and keep asking for frames,
        // so the encoder backs up and refuses further frame requests.
        held = 1'b1;
        hold_asks <= hold_asks + 1;
        repeat (8) offer_request(swfe_pkg::KIND_FRAME, status, pad);
        items += 8;
      end else if (!drained && items >= 300) begin
        drained = 1'b1;
        wait_for_frames_out();
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
          offer_request(swfe_pkg::KIND_FRAME, status, pad);
          items++;
        end else if (roll < 82) begin
          offer_request(swfe_pkg::KIND_TICK, status, pad);
          items++;
        end else if (roll < 88) begin
          // A short run of ticks carries into the millisecond tens and can reach the hundreds.
          n = $urandom_range(10, 40);
          repeat (n)
            offer_request(swfe_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                          2'($urandom_range(0, 3)));
          items += n;
        end else if (roll < 94) begin
          offer_request(swfe_pkg::KIND_CLEAR, status, pad);
          items++;
        end else begin
          offer_request(swfe_pkg::KIND_UNUSED, status, pad);
          items++;
        end
      end
    end

    // A last few frames around a clear.
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_LEFT);
    offer_request(swfe_pkg::KIND_TICK, 8'h00, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_FRAME, 8'hFF, swfe_pkg::PAD_RIGHT);
    offer_request(swfe_pkg::KIND_CLEAR, 8'h00, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_TICK, 8'h00, swfe_pkg::PAD_NONE);
    offer_request(swfe_pkg::KIND_FRAME, swfe_pkg::CHAR_IDLE, swfe_pkg::PAD_RIGHT);

    wait_for_frames_out();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && bytes_due == 0)
      $display("tb_stopwatch_serial_frame_encoder OK");
    else
      $display("tb_stopwatch_serial_frame_encoder NOT OK");
    $finish;
  end

endmodule
